// ===== design/hsd_pkg.sv =====
// package: shared widths, constants, cordic tables and data types
`timescale 1ns / 1ps
package hsd_pkg;

    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int RADIUS_W = 13;
    localparam int DIST_W   = 23;
    localparam int ADDR_W   = 3;
    localparam int CW       = 36;
    localparam int TW       = 32;
    localparam int AW       = 31;
    localparam int SQW      = 62;
    localparam int SQ_STEPS = 31;
    localparam int ATAN_LEN = 32;
    localparam int CCW      = 32;
    localparam int PRODC_W  = RADIUS_W + CCW;

    localparam logic [ADDR_W-3:0] REG_RADIUS = '0;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 13'd6378;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_t;

    typedef struct packed {
        logic [SQW-1:0] rem;
        logic [SQW-1:0] res;
    } sq_t;

    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        begin
            q = '0;
            r = '0;
            for (int i = 63; i >= 0; i--)
            begin
                r = {r[62:0], n[i]};
                if (r >= d)
                begin
                    r = r - d;
                    q[i] = 1'b1;
                end
            end
            return q;
        end
    endfunction

    function automatic logic [63:0] isqrt_calc(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] b;
        begin
            v = v_in;
            res = '0;
            b = 64'd1 << 62;
            while (b > v)
                b = b >> 2;
            while (b != 0)
            begin
                if (v >= res + b)
                begin
                    v = v - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        end
    endfunction

    function automatic longint atan_sum(input logic [63:0] p_in, input logic [63:0] d);
        logic [63:0] p;
        logic [63:0] k;
        longint s;
        longint t;
        begin
            p = p_in;
            k = '0;
            s = 0;
            while (p != 0)
            begin
                t = longint'(udiv(p, 2 * k + 1));
                s = k[0] ? s - t : s + t;
                p = udiv(p, d);
                k = k + 1;
            end
            return s;
        end
    endfunction

    function automatic longint q60_to_q30(input longint v);
        return (v + (longint'(1) << 29)) >>> 30;
    endfunction

    function automatic longint pi60_calc();
        logic [63:0] two60;
        begin
            two60 = 64'd1 << 60;
            return 16 * atan_sum(udiv(two60, 64'd5), 64'd25)
                 - 4 * atan_sum(udiv(two60, 64'd239), 64'd57121);
        end
    endfunction

    localparam longint PI60      = pi60_calc();
    localparam longint PI_Q      = q60_to_q30(PI60);
    localparam longint PI180_Q37 = (longint'(udiv(64'(PI60), 64'd45)) + (longint'(1) << 24)) >>> 25;

    localparam logic signed [CW-1:0] PI_S      = CW'(PI_Q);
    localparam logic signed [CW-1:0] HALF_PI_S = CW'(PI_Q >>> 1);
    localparam logic signed [CW-1:0] TWO_PI_S  = CW'(2 * PI_Q);
    localparam logic signed [32:0]   PI180_S   = 33'(PI180_Q37);

    function automatic longint atan_q30(input int i);
        begin
            if (i == 0)
                return q60_to_q30(longint'(udiv(64'(PI60), 64'd4)));
            return q60_to_q30(atan_sum(64'd1 << (60 - i), 64'd1 << (2 * i)));
        end
    endfunction

    function automatic longint gain_inv_calc(input int n);
        longint x;
        longint y;
        longint nx;
        longint ny;
        logic [63:0] g;
        begin
            x = longint'(1) << 30;
            y = 0;
            for (int i = 0; i < n; i++)
            begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                x = nx;
                y = ny;
            end
            g = isqrt_calc(64'(x * x) + 64'(y * y));
            if (g == 0)
                g = 64'd1;
            return longint'(udiv((64'd1 << 60) + (g >> 1), g));
        end
    endfunction

endpackage

// ===== design/hsd_in_if.sv =====
// interface: point pair input channel
`timescale 1ns / 1ps
interface hsd_in_if;
    logic valid;
    logic ready;
    logic signed [hsd_pkg::LAT_W-1:0] origin_lat;
    logic signed [hsd_pkg::LON_W-1:0] origin_lon;
    logic signed [hsd_pkg::LAT_W-1:0] dest_lat;
    logic signed [hsd_pkg::LON_W-1:0] dest_lon;

    modport source (output valid, origin_lat, origin_lon, dest_lat, dest_lon, input ready);
    modport sink (input valid, origin_lat, origin_lon, dest_lat, dest_lon, output ready);
endinterface

// ===== design/hsd_out_if.sv =====
// interface: distance output channel
`timescale 1ns / 1ps
interface hsd_out_if;
    logic valid;
    logic ready;
    logic [hsd_pkg::DIST_W-1:0] distance_km;

    modport source (output valid, distance_km, input ready);
    modport sink (input valid, distance_km, output ready);
endinterface

// ===== design/haversine_great_circle_distance.sv =====
// top level: pipelined haversine great-circle distance with radius register
//
//  channel   | dir | handshake      | word
//  points    | in  | valid / ready  | origin_lat, origin_lon, dest_lat, dest_lon
//  distance  | out | valid / ready  | distance_km (km, 8 fraction bits)
//  apb       | in  | psel / penable | sphere_radius_km at byte address 0
//
//  one word per cycle unless both output buffer words are full and not taken; stages capped at 32
//  the path runs through two cordic cell chains and the 31-cell square root chain
//  rst_n clears the valid line and the output buffer valid flags, and sets the radius to 6378
//  a two-word output buffer keeps accepting while one result waits
//  the whole pipeline holds only when both buffer words are full and not taken
`timescale 1ns / 1ps
module haversine_great_circle_distance #(
    parameter int CORDIC_STAGES = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hsd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    hsd_in_if.sink                      points,
    hsd_out_if.source                   distance
);
    import hsd_pkg::*;

    localparam int NST = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int LAT = 2 * NST + 40;
    localparam int PW = 65;
    localparam logic signed [CW-1:0] GAIN = CW'(gain_inv_calc(NST));
    localparam logic [AW-1:0] ONE_A = AW'(1) << 30;
    localparam int ST_FOLD = 4;
    localparam int ST_A = 7 + NST;

    // configuration
    logic [RADIUS_W-1:0] radius_reg;
    logic [RADIUS_W-1:0] radius_next;
    logic cfg_hit;

    assign cfg_hit = (paddr[ADDR_W-1:2] == REG_RADIUS);
    assign pready = 1'b1;
    assign prdata = (psel && cfg_hit) ? 32'(radius_reg) : 32'd0;

    always_comb
    begin
        radius_next = radius_reg;
        if (psel && penable && pwrite && cfg_hit)
            radius_next = pwdata[RADIUS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radius_reg <= RADIUS_RESET;
        else
            radius_reg <= radius_next;
    end

    // pipeline control
    logic en;
    logic in_fire;
    logic push;
    logic pop;
    logic [LAT-1:0] vld_reg;
    logic [LAT-1:0] vld_next;
    logic out_v_reg, out_v_next, spare_v_reg, spare_v_next;
    logic [DIST_W-1:0] out_d_reg, out_d_next, spare_d_reg, spare_d_next, push_d;

    assign en = !(out_v_reg && spare_v_reg) || distance.ready;
    assign points.ready = en;
    assign in_fire = points.valid && en;
    assign push = en && vld_reg[LAT-1];
    assign pop = out_v_reg && distance.ready;
    assign vld_next = en ? {vld_reg[LAT-2:0], in_fire} : vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    // degrees to radians, angle wrap, quadrant fold and cordic rotation
    logic signed [LON_W-1:0] deg [4];
    logic signed [PW-1:0] prod_reg [4];
    logic signed [CW-1:0] rad_reg [4];
    logic signed [CW-1:0] ang_reg [4];
    logic signed [CW-1:0] wrap_reg [4];
    logic signed [CW-1:0] wrap_next [4];
    vec_t fold_next [4];
    vec_t fold_reg [4];
    logic [1:0] neg_next;
    logic [1:0] neg_line [NST+1];
    vec_t rot_v [4][NST+1];

    assign deg[0] = LON_W'(points.origin_lat);
    assign deg[1] = points.origin_lon;
    assign deg[2] = LON_W'(points.dest_lat);
    assign deg[3] = points.dest_lon;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (ang_reg[k] > PI_S)
                wrap_next[k] = ang_reg[k] - TWO_PI_S;
            else if (ang_reg[k] < -PI_S)
                wrap_next[k] = ang_reg[k] + TWO_PI_S;
            else
                wrap_next[k] = ang_reg[k];
        end
        neg_next = 2'b00;
        for (int k = 0; k < 4; k++)
        begin
            fold_next[k].x = GAIN;
            fold_next[k].y = '0;
            fold_next[k].z = wrap_reg[k];
            if (wrap_reg[k] > HALF_PI_S)
            begin
                fold_next[k].z = PI_S - wrap_reg[k];
                if (k >= 2)
                    neg_next[k-2] = 1'b1;
            end
            else if (wrap_reg[k] < -HALF_PI_S)
            begin
                fold_next[k].z = -PI_S - wrap_reg[k];
                if (k >= 2)
                    neg_next[k-2] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= PW'(deg[k]) * PW'(PI180_S);
                rad_reg[k] <= CW'((prod_reg[k] + (PW'(1) << 29)) >>> 30);
                wrap_reg[k] <= wrap_next[k];
                fold_reg[k] <= fold_next[k];
            end
            ang_reg[0] <= (rad_reg[2] - rad_reg[0]) >>> 1;
            ang_reg[1] <= (rad_reg[3] - rad_reg[1]) >>> 1;
            ang_reg[2] <= rad_reg[2];
            ang_reg[3] <= rad_reg[0];
            neg_line[0] <= neg_next;
            for (int s = 1; s <= NST; s++)
                neg_line[s] <= neg_line[s-1];
        end
    end

    genvar gk, gs;
    generate
        for (gk = 0; gk < 4; gk++)
        begin : g_rot_lane
            assign rot_v[gk][0] = fold_reg[gk];
            for (gs = 0; gs < NST; gs++)
            begin : g_rot_cell
                hsd_cordic_cell #(.STAGE(gs), .VECTOR(1'b0)) u_cell (
                    .clk   (clk),
                    .en    (en),
                    .d_in  (rot_v[gk][gs]),
                    .d_out (rot_v[gk][gs+1])
                );
            end
        end
    endgenerate

    // haversine term
    logic signed [TW-1:0] sin1, sin2, cos1, cos2;
    logic signed [TW-1:0] s1sq_reg, s2sq_reg, c1_reg, c2_reg, s1sq_d_reg;
    logic signed [2*TW-1:0] m_s1, m_s2, m_c1, m_c2;
    logic signed [TW:0] a_sum;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] a_next;

    always_comb
    begin
        sin1 = TW'(rot_v[0][NST].y);
        sin2 = TW'(rot_v[1][NST].y);
        cos1 = neg_line[NST][0] ? -TW'(rot_v[2][NST].x) : TW'(rot_v[2][NST].x);
        cos2 = neg_line[NST][1] ? -TW'(rot_v[3][NST].x) : TW'(rot_v[3][NST].x);
        m_s1 = (2*TW)'(sin1) * (2*TW)'(sin1);
        m_s2 = (2*TW)'(sin2) * (2*TW)'(sin2);
        m_c1 = (2*TW)'(cos1) * (2*TW)'(cos2);
        m_c2 = (2*TW)'(c1_reg) * (2*TW)'(s2sq_reg);
        a_sum = (TW+1)'(s1sq_d_reg) + (TW+1)'(c2_reg);
        if (a_sum[TW])
            a_next = '0;
        else if (a_sum > (TW+1)'(ONE_A))
            a_next = ONE_A;
        else
            a_next = a_sum[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1sq_reg <= TW'(m_s1 >>> 30);
            s2sq_reg <= TW'(m_s2 >>> 30);
            c1_reg <= TW'(m_c1 >>> 30);
            c2_reg <= TW'(m_c2 >>> 30);
            s1sq_d_reg <= s1sq_reg;
            a_reg <= a_next;
        end
    end

    // square roots of a and 1 - a
    sq_t sq_v [2][SQ_STEPS+1];

    assign sq_v[0][0].rem = SQW'(a_reg) << 30;
    assign sq_v[0][0].res = '0;
    assign sq_v[1][0].rem = SQW'(ONE_A - a_reg) << 30;
    assign sq_v[1][0].res = '0;

    generate
        for (gk = 0; gk < 2; gk++)
        begin : g_sq_lane
            for (gs = 0; gs < SQ_STEPS; gs++)
            begin : g_sq_cell
                hsd_sqrt_cell #(.BIT(SQ_STEPS - 1 - gs)) u_cell (
                    .clk   (clk),
                    .en    (en),
                    .d_in  (sq_v[gk][gs]),
                    .d_out (sq_v[gk][gs+1])
                );
            end
        end
    endgenerate

    // atan2 by vectoring
    vec_t vc_v [NST+1];

    assign vc_v[0].x = CW'(sq_v[1][SQ_STEPS].res);
    assign vc_v[0].y = CW'(sq_v[0][SQ_STEPS].res);
    assign vc_v[0].z = '0;

    generate
        for (gs = 0; gs < NST; gs++)
        begin : g_vec_cell
            hsd_cordic_cell #(.STAGE(gs), .VECTOR(1'b1)) u_cell (
                .clk   (clk),
                .en    (en),
                .d_in  (vc_v[gs]),
                .d_out (vc_v[gs+1])
            );
        end
    endgenerate

    // scale by radius
    logic [CCW-1:0] c_val;
    logic [PRODC_W-1:0] prodc_reg;
    logic [PRODC_W-22:0] d_sum;

    always_comb
    begin
        c_val = vc_v[NST].z[CW-1] ? '0 : {vc_v[NST].z[CCW-2:0], 1'b0};
        d_sum = (PRODC_W-21)'((PRODC_W+1)'(prodc_reg) + (PRODC_W+1)'(1 << 21) >> 22);
        push_d = (d_sum[PRODC_W-22:DIST_W] != '0) ? {DIST_W{1'b1}} : d_sum[DIST_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prodc_reg <= PRODC_W'(radius_reg) * PRODC_W'(c_val);
    end

    // output buffer
    always_comb
    begin
        out_v_next = out_v_reg;
        out_d_next = out_d_reg;
        spare_v_next = spare_v_reg;
        spare_d_next = spare_d_reg;
        if (!out_v_reg || pop)
        begin
            if (spare_v_reg)
            begin
                out_v_next = 1'b1;
                out_d_next = spare_d_reg;
                spare_v_next = push;
                spare_d_next = push_d;
            end
            else
            begin
                out_v_next = push;
                out_d_next = push_d;
            end
        end
        else if (push)
        begin
            spare_v_next = 1'b1;
            spare_d_next = push_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            spare_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
            spare_v_reg <= spare_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg <= out_d_next;
        spare_d_reg <= spare_d_next;
    end

    assign distance.valid = out_v_reg;
    assign distance.distance_km = out_d_reg;

    a_spare_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        spare_v_reg |-> out_v_reg)
        else $error("spare word without head word");

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_FOLD] |-> (rot_v[2][0].z <= HALF_PI_S && rot_v[2][0].z >= -HALF_PI_S
                              && rot_v[0][0].z <= HALF_PI_S && rot_v[0][0].z >= -HALF_PI_S))
        else $error("folded angle out of range");

    a_a_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_A] |-> a_reg <= ONE_A)
        else $error("haversine term above one");
endmodule

// ===== design/hsd_cordic_cell.sv =====
// module: one cordic micro-rotation stage, rotation or vectoring mode
`timescale 1ns / 1ps
module hsd_cordic_cell #(
    parameter int STAGE = 0,
    parameter bit VECTOR = 1'b0
) (
    input  logic          clk,
    input  logic          en,
    input  hsd_pkg::vec_t d_in,
    output hsd_pkg::vec_t d_out
);
    import hsd_pkg::*;

    localparam logic signed [CW-1:0] ANGLE = CW'(atan_q30(STAGE));

    vec_t vec_reg;
    vec_t vec_next;
    logic pos;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;

    always_comb
    begin
        xs = d_in.x >>> STAGE;
        ys = d_in.y >>> STAGE;
        pos = VECTOR ? d_in.y[CW-1] : !d_in.z[CW-1];
        if (pos)
        begin
            vec_next.x = d_in.x - ys;
            vec_next.y = d_in.y + xs;
            vec_next.z = d_in.z - ANGLE;
        end
        else
        begin
            vec_next.x = d_in.x + ys;
            vec_next.y = d_in.y - xs;
            vec_next.z = d_in.z + ANGLE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign d_out = vec_reg;
endmodule

// ===== design/hsd_sqrt_cell.sv =====
// module: one result bit of the pipelined integer square root
`timescale 1ns / 1ps
module hsd_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic         clk,
    input  logic         en,
    input  hsd_pkg::sq_t d_in,
    output hsd_pkg::sq_t d_out
);
    import hsd_pkg::*;

    localparam logic [SQW-1:0] BITV = SQW'(1) << (2 * BIT);

    sq_t sq_reg;
    sq_t sq_next;
    logic [SQW-1:0] trial;

    always_comb
    begin
        trial = d_in.res + BITV;
        if (d_in.rem >= trial)
        begin
            sq_next.rem = d_in.rem - trial;
            sq_next.res = (d_in.res >> 1) + BITV;
        end
        else
        begin
            sq_next.rem = d_in.rem;
            sq_next.res = d_in.res >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg <= sq_next;
    end

    assign d_out = sq_reg;
endmodule
